@@ src/circle_outline_and_span_rasterizer_core_macros.svh @@
// assertion macros for the circle rasteriser rtl
// no dependencies; included by files that carry assertions
`ifndef CIRCLE_OUTLINE_AND_SPAN_RASTERIZER_CORE_MACROS_SVH
`define CIRCLE_OUTLINE_AND_SPAN_RASTERIZER_CORE_MACROS_SVH

// concurrent check on i_clk, masked while reset is held
`define COSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("cosr assertion failed");

// same check with a caller supplied message
`define COSR_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

@@ src/cosr_pkg.sv @@
// shared types, widths and helper functions for the circle rasteriser
// no dependencies; used by every module of the block
package cosr_pkg;

    localparam int COORD_BITS  = 15;
    localparam int RADIUS_BITS = 12;
    localparam int OFF_BITS    = RADIUS_BITS + 1;
    localparam int DEC_BITS    = RADIUS_BITS + 3;
    localparam int DEC_WIDE    = DEC_BITS + 1;
    localparam int OUT_BITS    = 16;
    localparam int IDX_BITS    = 3;

    localparam int COORD_WIDE = (COORD_BITS > OUT_BITS) ? COORD_BITS : OUT_BITS;
    localparam int OFF_WIDE   = (OFF_BITS > OUT_BITS) ? OFF_BITS : OUT_BITS;

    localparam logic [IDX_BITS-1:0] OUTLINE_LAST = IDX_BITS'(7);
    localparam logic [IDX_BITS-1:0] FILL_LAST    = IDX_BITS'(3);

    typedef enum logic {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                        fill;
        logic                        done;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [OFF_BITS-1:0]   ox;
        logic signed [OFF_BITS-1:0]   oy;
    } t_run;

    function automatic logic signed [OUT_BITS-1:0] coord_to_out(
        input logic signed [COORD_BITS-1:0] v
    );
        logic signed [COORD_WIDE-1:0] w;
        w = COORD_WIDE'(v);
        return w[OUT_BITS-1:0];
    endfunction

    function automatic logic signed [OUT_BITS-1:0] off_to_out(
        input logic signed [OFF_BITS-1:0] v
    );
        logic signed [OFF_WIDE-1:0] w;
        w = OFF_WIDE'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

@@ src/cosr_engine.sv @@
// circle state and the per-step decision update
// depends on cosr_pkg; hands a snapshot of each step to cosr_emit
module cosr_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_command,
    input  logic signed [cosr_pkg::COORD_BITS-1:0] i_center_x,
    input  logic signed [cosr_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [cosr_pkg::RADIUS_BITS-1:0]    i_radius,
    input  logic                                i_fill_mode,
    output logic                                o_load,
    output cosr_pkg::t_run                      o_run
);

    logic signed [cosr_pkg::COORD_BITS-1:0] r_cx, n_cx, r_cy, n_cy;
    logic [cosr_pkg::RADIUS_BITS-1:0]       r_rad, n_rad;
    logic signed [cosr_pkg::OFF_BITS-1:0]   r_ox, n_ox, r_oy, n_oy;
    logic signed [cosr_pkg::DEC_BITS-1:0]   r_dec, n_dec;
    logic                                   r_fill, n_fill, r_active, n_active;

    logic signed [cosr_pkg::DEC_WIDE-1:0]   d_w, x2_w, y2_w, r2_w;
    logic signed [cosr_pkg::OFF_BITS-1:0]   s_ox, s_oy;
    logic signed [cosr_pkg::DEC_BITS-1:0]   s_dec;
    logic                                   s_done, step_go;

    // three-way decision rule
    always_comb begin
        d_w  = cosr_pkg::DEC_WIDE'(r_dec);
        x2_w = cosr_pkg::DEC_WIDE'(r_ox) <<< 1;
        y2_w = cosr_pkg::DEC_WIDE'(r_oy) <<< 1;
        r2_w = (cosr_pkg::DEC_WIDE'($signed({1'b0, r_rad}))
                - cosr_pkg::DEC_WIDE'(r_oy)) <<< 1;
        s_ox  = r_ox;
        s_oy  = r_oy;
        priority if (d_w >= x2_w) begin
            s_dec = cosr_pkg::DEC_BITS'(d_w - x2_w - cosr_pkg::DEC_WIDE'(1));
            s_ox  = r_ox + cosr_pkg::OFF_BITS'(1);
        end else if (d_w < r2_w) begin
            s_dec = cosr_pkg::DEC_BITS'(d_w + y2_w - cosr_pkg::DEC_WIDE'(1));
            s_oy  = r_oy - cosr_pkg::OFF_BITS'(1);
        end else begin
            s_dec = cosr_pkg::DEC_BITS'(d_w + y2_w - x2_w - cosr_pkg::DEC_WIDE'(2));
            s_ox  = r_ox + cosr_pkg::OFF_BITS'(1);
            s_oy  = r_oy - cosr_pkg::OFF_BITS'(1);
        end
        s_done = s_oy < s_ox;
    end

    assign step_go = i_accept && (i_command == cosr_pkg::CMD_STEP) && r_active;

    always_comb begin
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_rad    = r_rad;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_dec    = r_dec;
        n_fill   = r_fill;
        n_active = r_active;
        if (i_accept && (i_command == cosr_pkg::CMD_START)) begin
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_rad    = i_radius;
            n_ox     = '0;
            n_oy     = $signed({1'b0, i_radius});
            n_dec    = cosr_pkg::DEC_BITS'($signed({1'b0, i_radius}))
                       - cosr_pkg::DEC_BITS'(1);
            n_fill   = i_fill_mode;
            n_active = 1'b1;
        end else if (step_go) begin
            n_ox     = s_ox;
            n_oy     = s_oy;
            n_dec    = s_dec;
            n_active = !s_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_rad    <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_dec    <= '0;
            r_fill   <= 1'b0;
            r_active <= 1'b0;
        end else begin
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_rad    <= n_rad;
            r_ox     <= n_ox;
            r_oy     <= n_oy;
            r_dec    <= n_dec;
            r_fill   <= n_fill;
            r_active <= n_active;
        end
    end

    assign o_load    = step_go;
    assign o_run     = '{fill: r_fill, done: s_done, cx: r_cx, cy: r_cy, ox: r_ox, oy: r_oy};

endmodule

@@ src/cosr_emit.sv @@
// run register, result sequencer and output register
// depends on cosr_pkg and the assertion macro header
`include "circle_outline_and_span_rasterizer_core_macros.svh"

module cosr_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  cosr_pkg::t_run                      i_run,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_left_x,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_right_x,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_row_y,
    output logic                                o_last_in_run,
    output logic                                o_circle_done
);

    cosr_pkg::t_run                     r_run;
    logic                               r_busy;
    logic [cosr_pkg::IDX_BITS-1:0]      r_idx;
    logic                               r_out_valid;
    logic signed [cosr_pkg::OUT_BITS-1:0] r_left, r_right, r_row;
    logic                               r_last, r_done;

    logic signed [cosr_pkg::OUT_BITS-1:0] cx, cy, ox, oy;
    logic signed [cosr_pkg::OUT_BITS-1:0] xpo, xmo, xpy, xmy, ypo, ymo, ypy, ymy;
    logic signed [cosr_pkg::OUT_BITS-1:0] n_left, n_right, n_row;
    logic                               out_adv, emit_now, is_last, finishing;

    always_comb begin
        cx  = cosr_pkg::coord_to_out(r_run.cx);
        cy  = cosr_pkg::coord_to_out(r_run.cy);
        ox  = cosr_pkg::off_to_out(r_run.ox);
        oy  = cosr_pkg::off_to_out(r_run.oy);
        xpo = cx + ox;
        xmo = cx - ox;
        xpy = cx + oy;
        xmy = cx - oy;
        ypo = cy + ox;
        ymo = cy - ox;
        ypy = cy + oy;
        ymy = cy - oy;
    end

    // span order within one step
    always_comb begin
        if (r_run.fill) begin
            unique case (r_idx[1:0])
                2'd0:    begin n_left = xmy; n_right = xpy; n_row = ypo; end
                2'd1:    begin n_left = xmo; n_right = xpo; n_row = ypy; end
                2'd2:    begin n_left = xmo; n_right = xpo; n_row = ymy; end
                default: begin n_left = xmy; n_right = xpy; n_row = ymo; end
            endcase
        end else begin
            unique case (r_idx)
                3'd0:    begin n_left = xpo; n_right = xpo; n_row = ypy; end
                3'd1:    begin n_left = xpy; n_right = xpy; n_row = ypo; end
                3'd2:    begin n_left = xmo; n_right = xmo; n_row = ypy; end
                3'd3:    begin n_left = xmy; n_right = xmy; n_row = ypo; end
                3'd4:    begin n_left = xpo; n_right = xpo; n_row = ymy; end
                3'd5:    begin n_left = xpy; n_right = xpy; n_row = ymo; end
                3'd6:    begin n_left = xmo; n_right = xmo; n_row = ymy; end
                default: begin n_left = xmy; n_right = xmy; n_row = ymo; end
            endcase
        end
    end

    assign out_adv   = !r_out_valid || !i_stall;
    assign emit_now  = r_busy && out_adv;
    assign is_last   = r_run.fill ? (r_idx == cosr_pkg::FILL_LAST)
                                  : (r_idx == cosr_pkg::OUTLINE_LAST);
    assign finishing = emit_now && is_last;
    assign o_free    = !r_busy || finishing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else begin
                if (finishing) begin
                    r_busy <= 1'b0;
                end
                if (emit_now) begin
                    r_idx <= r_idx + cosr_pkg::IDX_BITS'(1);
                end
            end
            if (out_adv) begin
                r_out_valid <= emit_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_run <= i_run;
        end
        if (emit_now) begin
            r_left  <= n_left;
            r_right <= n_right;
            r_row   <= n_row;
            r_last  <= is_last;
            r_done  <= is_last && r_run.done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_span_left_x  = r_left;
    assign o_span_right_x = r_right;
    assign o_span_row_y   = r_row;
    assign o_last_in_run  = r_last;
    assign o_circle_done  = r_done;

    `COSR_ASSERT_MSG(a_load_when_free, i_load |-> o_free, "run loaded over a busy run")
    `COSR_ASSERT(a_done_on_last, r_out_valid && r_done |-> r_last)
    `COSR_ASSERT(a_fill_idx_range, r_busy && r_run.fill |-> r_idx <= cosr_pkg::FILL_LAST)
    `COSR_ASSERT_MSG(a_finish_frees, finishing && !i_load |=> !r_busy, "run not released")

endmodule

@@ src/circle_outline_and_span_rasterizer_core.sv @@
// Circle outline and span rasteriser, integer Andres-style circle scheme.
// Input channel: i_valid / o_stall carries one request; command start loads
// centre, radius and fill mode and gives nothing, command step runs one
// iteration of the circle loop. A step in outline mode gives eight one-pixel
// spans, in fill mode four horizontal spans; a step with no circle in
// progress gives nothing.
// Output channel: o_valid / i_stall, one span per cycle unless stalled,
// from an output register; o_last_in_run marks the last span of a step
// and o_circle_done marks it when the circle has finished.
// A step is captured in the run register when it is taken; its spans then
// leave one by one through the output register. A step holds the span
// sequencer until its last span issues; a start does not use it. The next
// request is taken in the cycle the sequencer issues the last span of
// the current step. A stalled receiver holds the output register, the
// sequencer and then the input channel. Reset clears the circle state:
// no circle in progress. Depends on cosr_pkg, cosr_engine and cosr_emit.
module circle_outline_and_span_rasterizer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [cosr_pkg::COORD_BITS-1:0] i_center_x,
    input  logic signed [cosr_pkg::COORD_BITS-1:0] i_center_y,
    input  logic [cosr_pkg::RADIUS_BITS-1:0]    i_radius,
    input  logic                                i_fill_mode,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_left_x,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_right_x,
    output logic signed [cosr_pkg::OUT_BITS-1:0] o_span_row_y,
    output logic                                o_last_in_run,
    output logic                                o_circle_done
);

    logic           accept, load, free;
    cosr_pkg::t_run run;

    assign o_stall = !free;
    assign accept  = i_valid && free;

    cosr_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_command  (i_command),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_fill_mode(i_fill_mode),
        .o_load     (load),
        .o_run      (run)
    );

    cosr_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load),
        .i_run         (run),
        .o_free        (free),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_span_left_x (o_span_left_x),
        .o_span_right_x(o_span_right_x),
        .o_span_row_y  (o_span_row_y),
        .o_last_in_run (o_last_in_run),
        .o_circle_done (o_circle_done)
    );

endmodule

@@ tb/sv/circle_outline_and_span_rasterizer_core_test.sv @@
// self-checking testbench for circle_outline_and_span_rasterizer_core
// drives start and step requests, predicts every span and compares each one
// depends on cosr_pkg and the core rtl only
`timescale 1ns / 100ps

module circle_outline_and_span_rasterizer_core_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 250;
    localparam int QUIET_FROM   = 200;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic signed [cosr_pkg::OUT_BITS-1:0] left_x;
        logic signed [cosr_pkg::OUT_BITS-1:0] right_x;
        logic signed [cosr_pkg::OUT_BITS-1:0] row_y;
        logic                                 last;
        logic                                 done;
    } t_span;

    class t_circle_span_board;
        logic signed [cosr_pkg::COORD_BITS-1:0] ctr_x;
        logic signed [cosr_pkg::COORD_BITS-1:0] ctr_y;
        int    rad;
        int    off_x;
        int    off_y;
        int    dec;
        bit    fill;
        bit    drawing;
        t_span spans_due[$];
        int    errors;

        function new();
            ctr_x   = '0;
            ctr_y   = '0;
            rad     = 0;
            off_x   = 0;
            off_y   = 0;
            dec     = 0;
            fill    = 1'b0;
            drawing = 1'b0;
            errors  = 0;
        endfunction

        function t_span mk_span(int l, int r, int y);
            t_span s;
            s.left_x  = cosr_pkg::OUT_BITS'(l);
            s.right_x = cosr_pkg::OUT_BITS'(r);
            s.row_y   = cosr_pkg::OUT_BITS'(y);
            s.last    = 1'b0;
            s.done    = 1'b0;
            return s;
        endfunction

        function bit busy();
            return drawing && off_y >= off_x;
        endfunction

        // returns the number of spans the request causes, or 1 for a start, which causes none
        function int take_request(cosr_pkg::t_cmd cmd,
                                  logic signed [cosr_pkg::COORD_BITS-1:0] cx,
                                  logic signed [cosr_pkg::COORD_BITS-1:0] cy,
                                  logic [cosr_pkg::RADIUS_BITS-1:0] r, logic fm);
            t_span run[8];
            int    n;
            int    x;
            int    y;
            int    ox;
            int    oy;
            if (cmd == cosr_pkg::CMD_START) begin
                ctr_x   = cx;
                ctr_y   = cy;
                rad     = r;
                fill    = fm;
                off_x   = 0;
                off_y   = rad;
                dec     = rad - 1;
                drawing = 1'b1;
                return 1;
            end
            if (!busy())
                return 0;
            x  = ctr_x;
            y  = ctr_y;
            ox = off_x;
            oy = off_y;
            if (fill) begin
                run[0] = mk_span(x - oy, x + oy, y + ox);
                run[1] = mk_span(x - ox, x + ox, y + oy);
                run[2] = mk_span(x - ox, x + ox, y - oy);
                run[3] = mk_span(x - oy, x + oy, y - ox);
                n = 4;
            end else begin
                run[0] = mk_span(x + ox, x + ox, y + oy);
                run[1] = mk_span(x + oy, x + oy, y + ox);
                run[2] = mk_span(x - ox, x - ox, y + oy);
                run[3] = mk_span(x - oy, x - oy, y + ox);
                run[4] = mk_span(x + ox, x + ox, y - oy);
                run[5] = mk_span(x + oy, x + oy, y - ox);
                run[6] = mk_span(x - ox, x - ox, y - oy);
                run[7] = mk_span(x - oy, x - oy, y - ox);
                n = 8;
            end
            if (dec >= 2 * off_x) begin
                dec   = dec - (2 * off_x + 1);
                off_x = off_x + 1;
            end else if (dec < 2 * (rad - off_y)) begin
                dec   = dec + 2 * off_y - 1;
                off_y = off_y - 1;
            end else begin
                dec   = dec + 2 * (off_y - off_x - 1);
                off_y = off_y - 1;
                off_x = off_x + 1;
            end
            run[n-1].last = 1'b1;
            if (off_y < off_x) begin
                drawing       = 1'b0;
                run[n-1].done = 1'b1;
            end
            for (int i = 0; i < n; i++)
                spans_due.push_back(run[i]);
            return n;
        endfunction

        function void check_span(logic signed [cosr_pkg::OUT_BITS-1:0] l,
                                 logic signed [cosr_pkg::OUT_BITS-1:0] r,
                                 logic signed [cosr_pkg::OUT_BITS-1:0] y,
                                 logic last, logic done);
            t_span e;
            if (spans_due.size() == 0) begin
                $error("span with none due: left %0d right %0d row %0d", l, r, y);
                errors++;
                return;
            end
            e = spans_due.pop_front();
            if (l !== e.left_x) begin
                $error("span_left_x: expected %0d, got %0d", e.left_x, l);
                errors++;
            end
            if (r !== e.right_x) begin
                $error("span_right_x: expected %0d, got %0d", e.right_x, r);
                errors++;
            end
            if (y !== e.row_y) begin
                $error("span_row_y: expected %0d, got %0d", e.row_y, y);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_in_run: expected %0b, got %0b", e.last, last);
                errors++;
            end
            if (done !== e.done) begin
                $error("circle_done: expected %0b, got %0b", e.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                                    i_clk = 1'b0;
    logic                                    i_rst_n = 1'b0;
    logic                                    i_valid = 1'b0;
    logic                                    o_stall;
    logic                                    i_command = 1'b0;
    logic signed [cosr_pkg::COORD_BITS-1:0]  i_center_x = '0;
    logic signed [cosr_pkg::COORD_BITS-1:0]  i_center_y = '0;
    logic [cosr_pkg::RADIUS_BITS-1:0]        i_radius = '0;
    logic                                    i_fill_mode = 1'b0;
    logic                                    o_valid;
    logic                                    i_stall = 1'b0;
    logic signed [cosr_pkg::OUT_BITS-1:0]    o_span_left_x;
    logic signed [cosr_pkg::OUT_BITS-1:0]    o_span_right_x;
    logic signed [cosr_pkg::OUT_BITS-1:0]    o_span_row_y;
    logic                                    o_last_in_run;
    logic                                    o_circle_done;

    t_circle_span_board board = new();
    bit quiet = 1'b0;
    int items_sent = 0;
    int stall_left = 0;
    int cycles = 0;

    circle_outline_and_span_rasterizer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_fill_mode    (i_fill_mode),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span_left_x  (o_span_left_x),
        .o_span_right_x (o_span_right_x),
        .o_span_row_y   (o_span_row_y),
        .o_last_in_run  (o_last_in_run),
        .o_circle_done  (o_circle_done)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // span receiver with bursts of back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall)
                board.check_span(o_span_left_x, o_span_right_x, o_span_row_y,
                                 o_last_in_run, o_circle_done);
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall    <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 2);
                i_stall    <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(input cosr_pkg::t_cmd cmd,
                                input logic signed [cosr_pkg::COORD_BITS-1:0] cx,
                                input logic signed [cosr_pkg::COORD_BITS-1:0] cy,
                                input logic [cosr_pkg::RADIUS_BITS-1:0] r,
                                input logic fm);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_center_x  <= cx;
        i_center_y  <= cy;
        i_radius    <= r;
        i_fill_mode <= fm;
        do @(posedge i_clk); while (o_stall);
        if (board.take_request(cmd, cx, cy, r, fm) != 0)
            items_sent++;
    endtask

    task automatic start_circle(input int cx, input int cy, input int r, input bit fm);
        send_request(cosr_pkg::CMD_START, cosr_pkg::COORD_BITS'(cx),
                     cosr_pkg::COORD_BITS'(cy), cosr_pkg::RADIUS_BITS'(r), fm);
    endtask

    // step request with random junk in the start-only fields
    task automatic step_circle();
        send_request(cosr_pkg::CMD_STEP, cosr_pkg::COORD_BITS'($urandom),
                     cosr_pkg::COORD_BITS'($urandom),
                     cosr_pkg::RADIUS_BITS'($urandom), 1'($urandom));
    endtask

    initial begin
        int  r;
        int  cap;
        int  k;
        bit  big;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // step with nothing in progress
        step_circle();
        // zero radius, outline then fill, then step after completion
        start_circle(0, 0, 0, 1'b0);
        step_circle();
        step_circle();
        start_circle(-16384, 16383, 0, 1'b1);
        step_circle();
        // widest radius at extreme centres, abandoned by a new start
        start_circle(16383, 16383, 4095, 1'b0);
        repeat (3) step_circle();
        start_circle(-16384, -16384, 4095, 1'b1);
        repeat (3) step_circle();
        start_circle(-1, -1, 1, 1'b0);
        repeat (3) step_circle();
        start_circle(16383, -16384, 2, 1'b1);
        repeat (4) step_circle();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = (items_sent >= QUIET_FROM);
            big   = ($urandom_range(0, 9) == 0);
            r     = big ? $urandom_range(0, 4095) : $urandom_range(0, 30);
            start_circle($urandom, $urandom, r, 1'($urandom));
            if (big)
                cap = $urandom_range(1, 8);
            else if ($urandom_range(0, 7) == 0)
                cap = $urandom_range(0, 4);
            else
                cap = 1000;
            k = 0;
            while (board.busy() && k < cap) begin
                step_circle();
                k++;
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 2)) step_circle();
        end
        i_valid <= 1'b0;

        while (board.spans_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
